// File: hw/rtl/touch_filter_press_tracker_defines.svh
// Assertion macros shared by the touch press tracker checkers.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef TOUCH_FILTER_PRESS_TRACKER_DEFINES_SVH
`define TOUCH_FILTER_PRESS_TRACKER_DEFINES_SVH

// A property that must hold at every clock edge out of reset.
`define TFPT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A condition in one cycle that forces another in the next cycle.
`define TFPT_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: hw/rtl/tfpt_pkg.sv
// Shared constants, codes and types of the touch press tracker.
// Used by the controller, the datapath, the top level and the checker.
package tfpt_pkg;

	localparam int SAMPLES_PER_GROUP = 5;
	localparam int TRIM_EACH_END     = 1;
	localparam int ADC_BITS          = 12;

	localparam int TRIM_EFF = (2 * TRIM_EACH_END >= SAMPLES_PER_GROUP) ?
		(SAMPLES_PER_GROUP - 1) / 2 : TRIM_EACH_END;
	localparam int KEEP_CNT = SAMPLES_PER_GROUP - 2 * TRIM_EFF;
	localparam int KEEP_LOG = $clog2(KEEP_CNT);
	localparam int SUM_W    = ADC_BITS + KEEP_LOG;
	localparam int DIV_SH   = SUM_W + KEEP_LOG;
	localparam int DIV_W    = DIV_SH + 1;
	localparam int MPROD_W  = SUM_W + DIV_W;
	localparam logic [DIV_W-1:0] DIV_MUL =
		DIV_W'(((64'd1 << DIV_SH) + 64'(KEEP_CNT) - 64'd1) / 64'(KEEP_CNT));

	localparam int POS_W  = $clog2(SAMPLES_PER_GROUP);
	localparam int RANK_W = $clog2(SAMPLES_PER_GROUP + 1);
	localparam int GROUPS = 4;
	localparam int GRP_W  = 2;

	localparam int COORD_W    = 16;
	localparam int GAIN_W     = 22;
	localparam int OFFSET_W   = 16;
	localparam int ERANGE_W   = 12;
	localparam int FRAC_BITS  = 20;
	localparam int CFG_DATA_W = 22;
	localparam int CFG_IDX_W  = 3;

	localparam int PROD_W    = GAIN_W + ADC_BITS + 1;
	localparam int OFFS_SH_W = OFFSET_W + FRAC_BITS;
	localparam int SCALE_W   = ((PROD_W > OFFS_SH_W) ? PROD_W : OFFS_SH_W) + 1;

	localparam logic [COORD_W-1:0]  IDLE_COORD     = 16'hFFFF;
	localparam logic [GAIN_W-1:0]   X_GAIN_RESET   = 22'd68917;
	localparam logic [OFFSET_W-1:0] X_OFFSET_RESET = 16'hFFF4;
	localparam logic [GAIN_W-1:0]   Y_GAIN_RESET   = 22'd93503;
	localparam logic [OFFSET_W-1:0] Y_OFFSET_RESET = 16'hFFF1;
	localparam logic [ERANGE_W-1:0] ERANGE_RESET   = 12'd50;

	typedef logic [ADC_BITS-1:0] adc_t;
	typedef logic [COORD_W-1:0]  coord_t;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_PENUP  = 2'd1,
		OP_ACK    = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE     = 3'd0,
		CFG_X_GAIN   = 3'd1,
		CFG_X_OFFSET = 3'd2,
		CFG_Y_GAIN   = 3'd3,
		CFG_Y_OFFSET = 3'd4,
		CFG_ERANGE   = 3'd5
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RANK,
		ST_SUM,
		ST_MEAN,
		ST_CHECK,
		ST_MULX,
		ST_MULY,
		ST_FIN,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic             store;
		logic             penup;
		logic             ack;
		logic             rank;
		logic             sum;
		logic             mean;
		logic             check;
		logic             mulx;
		logic             muly;
		logic             fin;
		logic             update;
		logic             load;
		logic [POS_W-1:0] pos;
		logic [GRP_W-1:0] grp;
	} cmd_t;

endpackage

// File: hw/rtl/tfpt_ctrl.sv
// Sequencer of the touch press tracker: sample counters, scan steps and output valid.
// Depends on tfpt_pkg; drives the datapath through a cmd_t bundle.
module tfpt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            operation,
	output logic                  out_valid,
	input  logic                  out_stall,
	output tfpt_pkg::cmd_t        cmd
);
	import tfpt_pkg::*;

	state_t           state_q, state_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [GRP_W-1:0] grp_q, grp_d;
	logic             out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			grp_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			pos_q       <= pos_d;
			grp_q       <= grp_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pos_d   = pos_q;
		grp_d   = grp_q;
		cmd     = '0;
		cmd.pos = pos_q;
		cmd.grp = grp_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (op_t'(operation))
						OP_SAMPLE: begin
							cmd.store = 1'b1;
							if (pos_q == POS_W'(SAMPLES_PER_GROUP - 1)) begin
								pos_d   = '0;
								state_d = ST_RANK;
							end else begin
								pos_d = pos_q + 1'b1;
							end
						end
						OP_PENUP: begin
							cmd.penup = 1'b1;
							pos_d     = '0;
							grp_d     = '0;
							state_d   = ST_EMIT;
						end
						OP_ACK: begin
							cmd.ack = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_RANK: begin
				cmd.rank = 1'b1;
				state_d  = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_MEAN;
			end
			ST_MEAN: begin
				cmd.mean = 1'b1;
				if (grp_q == GRP_W'(GROUPS - 1)) begin
					grp_d   = '0;
					state_d = ST_CHECK;
				end else begin
					grp_d   = grp_q + 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = ST_MULX;
			end
			ST_MULX: begin
				cmd.mulx = 1'b1;
				state_d  = ST_MULY;
			end
			ST_MULY: begin
				cmd.muly = 1'b1;
				state_d  = ST_FIN;
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (cmd.load) begin
			out_valid_d = 1'b1;
		end else begin
			out_valid_d = out_valid_q && out_stall;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: hw/rtl/tfpt_dp.sv
// Datapath of the touch press tracker: sample buffer, trimmed mean, checks,
// scaling, press state, configuration registers and the output register. Depends on tfpt_pkg.
module tfpt_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tfpt_pkg::cmd_t                cmd,
	input  tfpt_pkg::adc_t                sample,
	input  logic                          cfg_write,
	input  logic [tfpt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tfpt_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                          pressed,
	output logic                          caught,
	output logic                          read_ok,
	output tfpt_pkg::coord_t              x_coord,
	output tfpt_pkg::coord_t              y_coord,
	output tfpt_pkg::coord_t              first_x,
	output tfpt_pkg::coord_t              first_y
);
	import tfpt_pkg::*;

	logic                       mode_q;
	logic signed [GAIN_W-1:0]   x_gain_q, y_gain_q;
	logic signed [OFFSET_W-1:0] x_offset_q, y_offset_q;
	logic [ERANGE_W-1:0]        erange_q;

	adc_t                    buf_q [SAMPLES_PER_GROUP];
	logic [RANK_W-1:0]       rank_c [SAMPLES_PER_GROUP];
	logic [SAMPLES_PER_GROUP-1:0] keep_c, keep_q;
	logic [SUM_W-1:0]        sum_c, sum_q;
	logic [MPROD_W-1:0]      mprod_c;
	adc_t                    mean_c;
	adc_t                    x1_q, y1_q, x2_q, y2_q;

	adc_t                    dx_c, dy_c;
	logic                    ok_q;
	adc_t                    avg_x_q, avg_y_q;

	logic signed [GAIN_W-1:0]   mul_gain_c;
	logic signed [ADC_BITS:0]   mul_avg_c;
	logic signed [PROD_W-1:0]   prod_s1;
	logic signed [OFFSET_W-1:0] off_sel_c;
	logic signed [SCALE_W-1:0]  sc_t_c, sc_adj_c;
	coord_t                     scaled_c, scaled_x_q, scaled_y_q;

	logic                    pressed_q, caught_q;
	coord_t                  cur_x_q, cur_y_q, first_x_q, first_y_q;
	coord_t                  new_x_c, new_y_c;

	logic                    out_pressed_q, out_caught_q, out_ok_q;
	coord_t                  out_x_q, out_y_q, out_fx_q, out_fy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			x_gain_q   <= X_GAIN_RESET;
			x_offset_q <= X_OFFSET_RESET;
			y_gain_q   <= Y_GAIN_RESET;
			y_offset_q <= Y_OFFSET_RESET;
			erange_q   <= ERANGE_RESET;
		end else if (cfg_write) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MODE:     mode_q     <= cfg_data[0];
				CFG_X_GAIN:   x_gain_q   <= cfg_data[GAIN_W-1:0];
				CFG_X_OFFSET: x_offset_q <= cfg_data[OFFSET_W-1:0];
				CFG_Y_GAIN:   y_gain_q   <= cfg_data[GAIN_W-1:0];
				CFG_Y_OFFSET: y_offset_q <= cfg_data[OFFSET_W-1:0];
				CFG_ERANGE:   erange_q   <= cfg_data[ERANGE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			buf_q[cmd.pos] <= sample;
		end
	end

	// A sample's rank is its place in sorted order, ties broken by slot.
	always_comb begin
		for (int i = 0; i < SAMPLES_PER_GROUP; i++) begin
			rank_c[i] = '0;
			for (int j = 0; j < SAMPLES_PER_GROUP; j++) begin
				if (j != i && (buf_q[j] < buf_q[i] || (buf_q[j] == buf_q[i] && j < i))) begin
					rank_c[i] = rank_c[i] + 1'b1;
				end
			end
			keep_c[i] = (rank_c[i] >= RANK_W'(TRIM_EFF)) &&
				(rank_c[i] < RANK_W'(SAMPLES_PER_GROUP - TRIM_EFF));
		end
	end

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < SAMPLES_PER_GROUP; i++) begin
			if (keep_q[i]) begin
				sum_c = sum_c + SUM_W'(buf_q[i]);
			end
		end
	end

	// Division by the kept count as a multiply by its rounded-up reciprocal.
	assign mprod_c = MPROD_W'(sum_q) * MPROD_W'(DIV_MUL);
	assign mean_c  = mprod_c[DIV_SH +: ADC_BITS];

	always_ff @(posedge clk) begin
		if (cmd.rank) begin
			keep_q <= keep_c;
		end
		if (cmd.sum) begin
			sum_q <= sum_c;
		end
		if (cmd.mean) begin
			unique case (cmd.grp)
				2'd0: x1_q <= mean_c;
				2'd1: y1_q <= mean_c;
				2'd2: x2_q <= mean_c;
				2'd3: y2_q <= mean_c;
			endcase
		end
	end

	assign dx_c = (x1_q > x2_q) ? x1_q - x2_q : x2_q - x1_q;
	assign dy_c = (y1_q > y2_q) ? y1_q - y2_q : y2_q - y1_q;

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			avg_x_q <= ADC_BITS'(({1'b0, x1_q} + {1'b0, x2_q}) >> 1);
			avg_y_q <= ADC_BITS'(({1'b0, y1_q} + {1'b0, y2_q}) >> 1);
		end
	end

	// One shared multiplier: X product first, then Y.
	assign mul_gain_c = cmd.muly ? y_gain_q : x_gain_q;
	assign mul_avg_c  = cmd.muly ? signed'({1'b0, avg_y_q}) : signed'({1'b0, avg_x_q});
	assign off_sel_c  = cmd.fin ? y_offset_q : x_offset_q;

	// Add the offset, then shift right rounding toward zero.
	assign sc_t_c   = SCALE_W'(prod_s1) + (SCALE_W'(off_sel_c) <<< FRAC_BITS);
	assign sc_adj_c = sc_t_c + (sc_t_c[SCALE_W-1] ?
		SCALE_W'((64'd1 << FRAC_BITS) - 64'd1) : SCALE_W'(0));
	assign scaled_c = sc_adj_c[FRAC_BITS +: COORD_W];

	always_ff @(posedge clk) begin
		if (cmd.mulx || cmd.muly) begin
			prod_s1 <= PROD_W'(mul_gain_c) * PROD_W'(mul_avg_c);
		end
		if (cmd.muly) begin
			scaled_x_q <= scaled_c;
		end
		if (cmd.fin) begin
			scaled_y_q <= scaled_c;
		end
	end

	assign new_x_c = !ok_q ? cur_x_q : (mode_q ? COORD_W'(avg_x_q) : scaled_x_q);
	assign new_y_c = !ok_q ? cur_y_q : (mode_q ? COORD_W'(avg_y_q) : scaled_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q      <= 1'b0;
			pressed_q <= 1'b0;
			caught_q  <= 1'b0;
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			first_x_q <= '0;
			first_y_q <= '0;
		end else begin
			if (cmd.check) begin
				ok_q <= (dx_c < erange_q) && (dy_c < erange_q);
			end
			if (cmd.update) begin
				cur_x_q <= new_x_c;
				cur_y_q <= new_y_c;
				if (!pressed_q) begin
					pressed_q <= 1'b1;
					caught_q  <= 1'b1;
					first_x_q <= new_x_c;
					first_y_q <= new_y_c;
				end
			end
			if (cmd.penup) begin
				ok_q <= 1'b0;
				if (pressed_q) begin
					pressed_q <= 1'b0;
				end else begin
					first_x_q <= '0;
					first_y_q <= '0;
					cur_x_q   <= IDLE_COORD;
					cur_y_q   <= IDLE_COORD;
				end
			end
			if (cmd.ack) begin
				caught_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_pressed_q <= pressed_q;
			out_caught_q  <= caught_q;
			out_ok_q      <= ok_q;
			out_x_q       <= cur_x_q;
			out_y_q       <= cur_y_q;
			out_fx_q      <= first_x_q;
			out_fy_q      <= first_y_q;
		end
	end

	assign pressed = out_pressed_q;
	assign caught  = out_caught_q;
	assign read_ok = out_ok_q;
	assign x_coord = out_x_q;
	assign y_coord = out_y_q;
	assign first_x = out_fx_q;
	assign first_y = out_fy_q;

endmodule

// File: hw/rtl/touch_filter_press_tracker.sv
// Touch press tracker: takes one sample beat per cycle while a group of five
// fills; the end of each of the first three groups then holds the input for
// the rank, sum and mean steps, and the end of the fourth group for rank, sum,
// mean, check, two multiplies on one shared multiplier, final scale, update and
// output load, which waits while a held result is stalled. A full scan is
// twenty samples. A pen-up beat holds the input until its result is loaded
// into the output register; an acknowledge beat never holds it.
// A result waits in the output register while new input beats are taken.
// Depends on tfpt_pkg, tfpt_ctrl and tfpt_dp.
module touch_filter_press_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    operation,
	input  tfpt_pkg::adc_t                sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          pressed,
	output logic                          caught,
	output logic                          read_ok,
	output tfpt_pkg::coord_t              x_coord,
	output tfpt_pkg::coord_t              y_coord,
	output tfpt_pkg::coord_t              first_x,
	output tfpt_pkg::coord_t              first_y,
	input  logic                          cfg_write,
	input  logic [tfpt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tfpt_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tfpt_pkg::*;

	cmd_t cmd;

	tfpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	tfpt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sample    (sample),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pressed   (pressed),
		.caught    (caught),
		.read_ok   (read_ok),
		.x_coord   (x_coord),
		.y_coord   (y_coord),
		.first_x   (first_x),
		.first_y   (first_y)
	);

endmodule

// File: hw/rtl/tfpt_checker.sv
// Port-level checks of the touch press tracker, bound to the top level.
// Depends on tfpt_pkg and the assertion macros in touch_filter_press_tracker_defines.svh.
`include "touch_filter_press_tracker_defines.svh"

module tfpt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic [1:0]                    operation,
	input tfpt_pkg::adc_t                sample,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          pressed,
	input logic                          caught,
	input logic                          read_ok,
	input tfpt_pkg::coord_t              x_coord,
	input tfpt_pkg::coord_t              y_coord,
	input tfpt_pkg::coord_t              first_x,
	input tfpt_pkg::coord_t              first_y,
	input logic                          cfg_write,
	input logic [tfpt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [tfpt_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tfpt_pkg::*;

	// A stalled result beat keeps its valid and its coordinates.
	`TFPT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(x_coord) && $stable(y_coord) && $stable(read_ok), "result beat changed while stalled")

	// A scan that agreed always leaves the pen marked as pressed.
	`TFPT_ASSERT(a_ok_pressed, out_valid |-> (!read_ok || pressed), "read_ok without pressed")

	// A pen-up beat occupies the block until its result is loaded.
	`TFPT_ASSERT_NEXT(a_penup_busy, in_valid && !in_stall && operation == OP_PENUP, in_stall, "input not held after pen-up beat")

	// An acknowledge beat leaves the block ready for the next beat.
	`TFPT_ASSERT_NEXT(a_ack_ready, in_valid && !in_stall && operation == OP_ACK, !in_stall, "input stalled after acknowledge beat")

endmodule

bind touch_filter_press_tracker tfpt_checker u_tfpt_checker (.*);

// File: tb/sv/touch_press_board_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the touch press tracker: an untimed model of the trimmed-mean
// filter, the agreement check, the screen scaling and the press flags, with a
// queue of expected result beats. Depends on tfpt_pkg.
package touch_press_board_pkg;
	import tfpt_pkg::*;

	localparam int TRIM_USED = (2 * TRIM_EACH_END >= SAMPLES_PER_GROUP) ?
		(SAMPLES_PER_GROUP - 1) / 2 : TRIM_EACH_END;
	localparam int KEPT = SAMPLES_PER_GROUP - 2 * TRIM_USED;

	typedef struct packed {
		logic   pressed;
		logic   caught;
		logic   read_ok;
		coord_t x;
		coord_t y;
		coord_t fx;
		coord_t fy;
	} touch_report_t;

	class touch_press_board;
		logic                       raw_mode;
		logic signed [GAIN_W-1:0]   x_gain;
		logic signed [GAIN_W-1:0]   y_gain;
		logic signed [OFFSET_W-1:0] x_offset;
		logic signed [OFFSET_W-1:0] y_offset;
		logic [ERANGE_W-1:0]        agree_range;
		adc_t                       window[SAMPLES_PER_GROUP];
		int unsigned                samples_seen;
		adc_t                       x_first;
		adc_t                       y_first;
		adc_t                       x_second;
		logic                       down;
		logic                       seen;
		coord_t                     cur_x;
		coord_t                     cur_y;
		coord_t                     press_x;
		coord_t                     press_y;
		touch_report_t              pending_reports[$];
		int unsigned                failures;

		function new();
			raw_mode     = 1'b0;
			x_gain       = X_GAIN_RESET;
			x_offset     = X_OFFSET_RESET;
			y_gain       = Y_GAIN_RESET;
			y_offset     = Y_OFFSET_RESET;
			agree_range  = ERANGE_RESET;
			samples_seen = 0;
			down         = 1'b0;
			seen         = 1'b0;
			cur_x        = '0;
			cur_y        = '0;
			press_x      = '0;
			press_y      = '0;
			failures     = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
				CFG_MODE:     raw_mode    = v[0];
				CFG_X_GAIN:   x_gain      = v[GAIN_W-1:0];
				CFG_X_OFFSET: x_offset    = v[OFFSET_W-1:0];
				CFG_Y_GAIN:   y_gain      = v[GAIN_W-1:0];
				CFG_Y_OFFSET: y_offset    = v[OFFSET_W-1:0];
				CFG_ERANGE:   agree_range = v[ERANGE_W-1:0];
				default: ;
			endcase
		endfunction

		function adc_t trimmed_mean();
			adc_t        sorted[SAMPLES_PER_GROUP];
			adc_t        v;
			int          i;
			int          j;
			int unsigned total;
			sorted = window;
			for (i = 1; i < SAMPLES_PER_GROUP; i++) begin
				v = sorted[i];
				j = i;
				while (j > 0 && sorted[j - 1] > v) begin
					sorted[j] = sorted[j - 1];
					j--;
				end
				sorted[j] = v;
			end
			total = 0;
			for (i = TRIM_USED; i < SAMPLES_PER_GROUP - TRIM_USED; i++)
				total += sorted[i];
			return adc_t'(total / KEPT);
		endfunction

		function bit readings_agree(adc_t a, adc_t b);
			adc_t d;
			d = (a > b) ? a - b : b - a;
			return d < agree_range;
		endfunction

		function adc_t pair_mean(adc_t a, adc_t b);
			return adc_t'(({1'b0, a} + {1'b0, b}) >> 1);
		endfunction

		// Q20 scaling with the quotient truncated toward zero.
		function coord_t to_screen(adc_t avg, logic signed [GAIN_W-1:0] g,
				logic signed [OFFSET_W-1:0] o);
			longint acc;
			longint q;
			acc = longint'(g) * longint'(avg) + longint'(o) * 64'sd1048576;
			q = (acc >= 0) ? (acc >>> FRAC_BITS) : -((-acc) >>> FRAC_BITS);
			return coord_t'(q);
		endfunction

		function void queue_report(bit ok);
			touch_report_t r;
			r.pressed = down;
			r.caught  = seen;
			r.read_ok = ok;
			r.x       = cur_x;
			r.y       = cur_y;
			r.fx      = press_x;
			r.fy      = press_y;
			pending_reports.push_back(r);
		endfunction

		function void take_beat(logic [1:0] op, adc_t smp);
			int unsigned pos;
			int unsigned grp;
			adc_t        mean;
			adc_t        ax;
			adc_t        ay;
			bit          ok;
			if (op == OP_SAMPLE) begin
				pos = samples_seen % SAMPLES_PER_GROUP;
				grp = samples_seen / SAMPLES_PER_GROUP;
				window[pos] = smp;
				samples_seen++;
				if (pos + 1 < SAMPLES_PER_GROUP)
					return;
				mean = trimmed_mean();
				if (grp == 0) begin
					x_first = mean;
				end else if (grp == 1) begin
					y_first = mean;
				end else if (grp == 2) begin
					x_second = mean;
				end else begin
					samples_seen = 0;
					ok = readings_agree(x_first, x_second) && readings_agree(y_first, mean);
					if (ok) begin
						ax = pair_mean(x_first, x_second);
						ay = pair_mean(y_first, mean);
						cur_x = raw_mode ? coord_t'(ax) : to_screen(ax, x_gain, x_offset);
						cur_y = raw_mode ? coord_t'(ay) : to_screen(ay, y_gain, y_offset);
					end
					if (!down) begin
						down    = 1'b1;
						seen    = 1'b1;
						press_x = cur_x;
						press_y = cur_y;
					end
					queue_report(ok);
				end
			end else if (op == OP_PENUP) begin
				samples_seen = 0;
				if (down) begin
					down = 1'b0;
				end else begin
					press_x = '0;
					press_y = '0;
					cur_x   = IDLE_COORD;
					cur_y   = IDLE_COORD;
				end
				queue_report(1'b0);
			end else if (op == OP_ACK) begin
				seen = 1'b0;
			end
		endfunction

		function int unsigned pending();
			return pending_reports.size();
		endfunction

		task report(string what);
			failures++;
			if (failures <= 100)
				$display("%0t: mismatch: %s", $time, what);
		endtask

		task check_field(string name, logic [COORD_W-1:0] got, logic [COORD_W-1:0] want);
			if (got !== want)
				report($sformatf("%s is %0d, expected %0d", name, got, want));
		endtask

		task check_report(touch_report_t got);
			touch_report_t want;
			if (pending_reports.size() == 0) begin
				report($sformatf("result beat with none expected, x %0d y %0d", got.x, got.y));
				return;
			end
			want = pending_reports.pop_front();
			check_field("pressed", got.pressed, want.pressed);
			check_field("caught", got.caught, want.caught);
			check_field("read_ok", got.read_ok, want.read_ok);
			check_field("x_coord", got.x, want.x);
			check_field("y_coord", got.y, want.y);
			check_field("first_x", got.fx, want.fx);
			check_field("first_y", got.fy, want.fy);
		endtask
	endclass

endpackage

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the touch press tracker testbench: sends sample, pen-up and acknowledge
// beats, rewrites the registers between phases and checks every result beat.
// Depends on tfpt_pkg, touch_press_board_pkg and touch_filter_press_tracker.
module tb;
	import tfpt_pkg::*;
	import touch_press_board_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         ADC_MAX     = (1 << ADC_BITS) - 1;
	localparam int         GAIN_MAX    = 2097151;
	localparam int         GAIN_MIN    = -2097152;
	localparam int         OFFSET_MAX  = 32767;
	localparam int         OFFSET_MIN  = -32768;
	localparam int         ERANGE_MAX  = 4095;
	localparam int         PHASE_BEATS = 80;
	localparam int         HOLD_CYCLES = 400;
	localparam int         SETTLE      = 20;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	logic [1:0]            operation = OP_SAMPLE;
	adc_t                  sample    = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  pressed;
	logic                  caught;
	logic                  read_ok;
	coord_t                x_coord;
	coord_t                y_coord;
	coord_t                first_x;
	coord_t                first_y;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_MODE;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	touch_press_board board;
	int                send_idle    = 37;
	int                recv_idle    = 37;
	bit                hold_request = 1'b0;
	int unsigned       beats_sent   = 0;

	always #5 clk = ~clk;

	touch_filter_press_tracker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pressed   (pressed),
		.caught    (caught),
		.read_ok   (read_ok),
		.x_coord   (x_coord),
		.y_coord   (y_coord),
		.first_x   (first_x),
		.first_y   (first_y),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	task automatic send_beat(input logic [1:0] op, input adc_t smp);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		sample    <= smp;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.take_beat(op, smp);
		if (op != OP_UNUSED)
			beats_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic put_reg(input cfg_idx_t idx, input int value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(value);
		@(posedge clk);
		board.set_reg(idx, CFG_DATA_W'(value));
	endtask

	task automatic apply_setting(input int raw, input int xg, input int xo, input int yg,
			input int yo, input int er);
		put_reg(CFG_MODE, raw);
		put_reg(CFG_X_GAIN, xg);
		put_reg(CFG_X_OFFSET, xo);
		put_reg(CFG_Y_GAIN, yg);
		put_reg(CFG_Y_OFFSET, yo);
		put_reg(CFG_ERANGE, er);
		cfg_write <= 1'b0;
	endtask

	function automatic int pick_level();
		if ($urandom_range(7) == 0)
			return $urandom_range(1) ? ADC_MAX : 0;
		return $urandom_range(ADC_MAX);
	endfunction

	function automatic adc_t jitter(input int center, input int spread);
		int v;
		v = center + int'($urandom_range(2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > ADC_MAX)
			v = ADC_MAX;
		return adc_t'(v);
	endfunction

	// A full scan of X, Y, X, Y groups around one touch point, with stray
	// outliers, the odd acknowledge between groups, and now and then a group
	// of the second pair at a random level that may fail the agreement check.
	task automatic send_scan();
		int cx;
		int cy;
		int center;
		int spread;
		int g;
		int k;
		cx = pick_level();
		cy = pick_level();
		spread = ($urandom_range(3) == 0) ? 64 : 6;
		for (g = 0; g < 4; g++) begin
			center = (g % 2 == 0) ? cx : cy;
			if (g >= 2 && $urandom_range(5) == 0)
				center = $urandom_range(ADC_MAX);
			for (k = 0; k < SAMPLES_PER_GROUP; k++) begin
				if ($urandom_range(7) == 0)
					send_beat(OP_SAMPLE, adc_t'($urandom));
				else
					send_beat(OP_SAMPLE, jitter(center, spread));
			end
			if ($urandom_range(15) == 0)
				send_beat(OP_ACK, adc_t'($urandom));
		end
	endtask

	task automatic run_phase();
		int unsigned stop_at;
		int unsigned pick;
		int unsigned n;
		int unsigned k;
		stop_at = beats_sent + PHASE_BEATS;
		while (beats_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				send_scan();
			end else if (pick < 68) begin
				send_beat(OP_PENUP, adc_t'($urandom));
			end else if (pick < 78) begin
				send_beat(OP_ACK, adc_t'($urandom));
			end else if (pick < 92) begin
				n = $urandom_range(1, 4 * SAMPLES_PER_GROUP - 1);
				for (k = 0; k < n; k++)
					send_beat(OP_SAMPLE, adc_t'($urandom));
				send_beat(OP_PENUP, adc_t'($urandom));
			end else if (pick < 95) begin
				send_beat(OP_UNUSED, adc_t'($urandom));
			end else begin
				n = $urandom_range(1, 4);
				for (k = 0; k < n; k++)
					send_beat(OP_SAMPLE, adc_t'($urandom));
			end
		end
		send_beat(OP_PENUP, adc_t'($urandom));
		drain();
	endtask

	initial begin : receiver
		int            hold_left;
		touch_report_t got;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got = {pressed, caught, read_ok, x_coord, y_coord, first_x, first_y};
				board.check_report(got);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle);
			end
		end
	end

	initial begin : stimulus
		int g;
		int k;
		board = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pen-up from idle, the unused code, then one scan of full-scale X and
		// zero Y with one extreme per group to be trimmed off.
		send_beat(OP_PENUP, adc_t'(ADC_MAX));
		send_beat(OP_UNUSED, adc_t'(ADC_MAX));
		for (g = 0; g < 4; g++)
			for (k = 0; k < SAMPLES_PER_GROUP; k++)
				if (g % 2 == 0)
					send_beat(OP_SAMPLE, adc_t'((k == 2) ? 0 : ADC_MAX));
				else
					send_beat(OP_SAMPLE, adc_t'((k == 1) ? ADC_MAX : 0));
		send_beat(OP_ACK, '0);
		send_beat(OP_PENUP, '0);
		send_beat(OP_PENUP, '0);
		drain();

		apply_setting(1, X_GAIN_RESET, -12, Y_GAIN_RESET, -15, ERANGE_MAX);
		run_phase();

		send_idle = 0;
		recv_idle = 0;
		apply_setting(0, GAIN_MAX, OFFSET_MAX, GAIN_MIN, OFFSET_MIN, ERANGE_MAX);
		run_phase();
		send_idle = 37;
		recv_idle = 37;

		apply_setting(0, int'($urandom_range(4194303)) + GAIN_MIN,
			int'($urandom_range(65535)) + OFFSET_MIN,
			int'($urandom_range(4194303)) + GAIN_MIN,
			int'($urandom_range(65535)) + OFFSET_MIN, $urandom_range(1, 300));
		hold_request = 1'b1;
		run_phase();

		apply_setting(0, GAIN_MIN, OFFSET_MIN, GAIN_MAX, OFFSET_MAX, 0);
		run_phase();

		apply_setting(1, int'($urandom_range(4194303)) + GAIN_MIN,
			int'($urandom_range(65535)) + OFFSET_MIN,
			int'($urandom_range(4194303)) + GAIN_MIN,
			int'($urandom_range(65535)) + OFFSET_MIN, 200);
		run_phase();

		apply_setting(0, X_GAIN_RESET, -12, Y_GAIN_RESET, -15, ERANGE_RESET);
		run_phase();

		if (board.failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
